/* rtl/load_code_power_resistance_alu_assert.svh */
// Assertion macros shared by the load code ALU files.
// Define ASSERT_OFF to compile the assertions out.
`ifndef LOAD_CODE_POWER_RESISTANCE_ALU_ASSERT_SVH
`define LOAD_CODE_POWER_RESISTANCE_ALU_ASSERT_SVH

`ifndef ASSERT_OFF
`define LCPR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcpr: same-cycle check failed");
`define LCPR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcpr: next-cycle check failed");
`else
`define LCPR_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define LCPR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* rtl/lcpr_pkg.sv */
// ----------------------------------------------------------------------------
// lcpr_pkg
// Types and constants for the load code power / resistance ALU.
// ----------------------------------------------------------------------------
package lcpr_pkg;

  localparam int A_W         = 32;   // first_code width
  localparam int B_W         = 24;   // second_code / divisor width
  localparam int RES_W       = 32;   // result_code width
  localparam int POWER_SHIFT = 13;
  localparam int RES_SHIFT   = 16;
  localparam int NUM_W       = A_W + RES_SHIFT;   // widest dividend
  localparam int PROD_W      = A_W + B_W;
  localparam int WORD_W      = B_W + NUM_W;       // {remainder, dividend/quotient}
  localparam int N_CELLS     = NUM_W;             // one quotient bit per cell

  localparam logic [RES_W-1:0] DERIVED_LIMIT        = 32'hffff_ffff;
  localparam logic [B_W-1:0]   MEASURE_MAX_CODE_DEF = 24'hff_ffff;

  typedef enum logic [1:0] {
    OP_POWER = 2'd0,
    OP_RES   = 2'd1,
    OP_MEAS  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic               valid;
    op_t                op;
    logic [B_W-1:0]     divisor;
    logic [WORD_W-1:0]  word;
  } stage_t;

endpackage

/* rtl/lcpr_prep.sv */
// ----------------------------------------------------------------------------
// lcpr_prep
// Input register: forms the dividend or the full power product per item.
// ----------------------------------------------------------------------------
module lcpr_prep import lcpr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             in_valid,
  input  logic [1:0]       operation,
  input  logic [A_W-1:0]   first_code,
  input  logic [B_W-1:0]   second_code,
  output stage_t           stage_out
);

  op_t                op;
  logic [PROD_W-1:0]  prod;
  logic [WORD_W-1:0]  word_next;

  assign op   = op_t'(operation);
  assign prod = {{B_W{1'b0}}, first_code} * {{A_W{1'b0}}, second_code};

  always_comb begin
    case (op)
      OP_POWER: word_next = {{(WORD_W-PROD_W){1'b0}}, prod};
      OP_RES:   word_next = {{B_W{1'b0}}, first_code, {RES_SHIFT{1'b0}}};
      OP_MEAS:  word_next = {{(B_W+RES_SHIFT-POWER_SHIFT){1'b0}}, first_code,
                             {POWER_SHIFT{1'b0}}};
      default:  word_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else if (advance) begin
      stage_out.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stage_out.op      <= op;
      stage_out.divisor <= second_code;
      stage_out.word    <= word_next;
    end
  end

endmodule

/* rtl/lcpr_cell.sv */
// ----------------------------------------------------------------------------
// lcpr_cell
// One restoring-divide step: shifts one dividend bit into the remainder and
// shifts one quotient bit in. Non-divide items pass through untouched.
// ----------------------------------------------------------------------------
module lcpr_cell import lcpr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   advance,
  input  stage_t stage_in,
  output stage_t stage_out
);

  logic                dividing;
  logic [B_W:0]        trial;
  logic [B_W:0]        diff;
  logic                fits;
  logic [WORD_W-1:0]   word_next;

  assign dividing = (stage_in.op == OP_RES) || (stage_in.op == OP_MEAS);
  assign trial    = {stage_in.word[WORD_W-1:NUM_W], stage_in.word[NUM_W-1]};
  assign diff     = trial - {1'b0, stage_in.divisor};
  assign fits     = trial >= {1'b0, stage_in.divisor};

  always_comb begin
    if (!dividing) begin
      word_next = stage_in.word;
    end else if (fits) begin
      word_next = {diff[B_W-1:0], stage_in.word[NUM_W-2:0], 1'b1};
    end else begin
      word_next = {trial[B_W-1:0], stage_in.word[NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else if (advance) begin
      stage_out.valid <= stage_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stage_out.op      <= stage_in.op;
      stage_out.divisor <= stage_in.divisor;
      stage_out.word    <= word_next;
    end
  end

`include "load_code_power_resistance_alu_assert.svh"

  // partial remainder always stays below a nonzero divisor
  `LCPR_ASSERT_SAME(a_rem_below_div, clk, rst,
    stage_out.valid && (stage_out.op == OP_RES || stage_out.op == OP_MEAS)
      && stage_out.divisor != '0,
    stage_out.word[WORD_W-1:NUM_W] < stage_out.divisor)

endmodule

/* rtl/lcpr_finish.sv */
// ----------------------------------------------------------------------------
// lcpr_finish
// Output register: scales the product, applies saturation and the zero
// divisor rule, and holds the result until transferred.
// ----------------------------------------------------------------------------
module lcpr_finish import lcpr_pkg::*; #(
  parameter logic [B_W-1:0] MEASURE_MAX_CODE = MEASURE_MAX_CODE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  stage_t           stage_in,
  output logic             out_valid,
  output logic [RES_W-1:0] result_code,
  output logic             saturated,
  output logic             divide_by_zero
);

  localparam logic [RES_W-1:0] MEAS_LIMIT = {{(RES_W-B_W){1'b0}}, MEASURE_MAX_CODE};

  logic [PROD_W-POWER_SHIFT-1:0] power;
  logic [NUM_W-1:0]              quot;
  logic                          div_zero;
  logic [RES_W-1:0]              result_next;
  logic                          sat_next;
  logic                          dz_next;

  assign power    = stage_in.word[PROD_W-1:POWER_SHIFT];
  assign quot     = stage_in.word[NUM_W-1:0];
  assign div_zero = stage_in.divisor == '0;

  always_comb begin
    result_next = '0;
    sat_next    = 1'b0;
    dz_next     = 1'b0;
    case (stage_in.op)
      OP_POWER: begin
        if (power[PROD_W-POWER_SHIFT-1:RES_W] != '0) begin
          result_next = DERIVED_LIMIT;
          sat_next    = 1'b1;
        end else begin
          result_next = power[RES_W-1:0];
        end
      end
      OP_RES: begin
        if (div_zero || quot[NUM_W-1:RES_W] != '0) begin
          result_next = DERIVED_LIMIT;
          sat_next    = 1'b1;
          dz_next     = div_zero;
        end else begin
          result_next = quot[RES_W-1:0];
        end
      end
      OP_MEAS: begin
        if (div_zero || quot > {{(NUM_W-RES_W){1'b0}}, MEAS_LIMIT}) begin
          result_next = MEAS_LIMIT;
          sat_next    = 1'b1;
          dz_next     = div_zero;
        end else begin
          result_next = quot[RES_W-1:0];
        end
      end
      default: begin
        result_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_code    <= result_next;
      saturated      <= sat_next;
      divide_by_zero <= dz_next;
    end
  end

`include "load_code_power_resistance_alu_assert.svh"

  `LCPR_ASSERT_SAME(a_dz_implies_sat, clk, rst,
    out_valid && divide_by_zero, saturated)
  `LCPR_ASSERT_SAME(a_sat_is_limit, clk, rst,
    out_valid && saturated,
    result_code == DERIVED_LIMIT || result_code == MEAS_LIMIT)
  // a transfer with a valid final cell must present a fresh result next cycle
  `LCPR_ASSERT_NEXT(a_result_follows, clk, rst,
    advance && stage_in.valid, out_valid)

endmodule

/* rtl/load_code_power_resistance_alu.sv */
// ----------------------------------------------------------------------------
// load_code_power_resistance_alu
// Power, resistance and measurement-from-power codes for an electronic load,
// computed by an input multiplier and a row of one-bit restoring divide cells.
//
//   channel  signals                                   direction
//   in       in_valid in_ready operation first_code      sink
//            second_code
//   out      out_valid out_ready result_code saturated   source
//            divide_by_zero
//
// One item per cycle while the output is not stalled; the row is an input register,
// 48 divide cells (one quotient bit each, 48-bit dividend) and an output register.
// A stalled output register freezes the whole row, so in_ready follows
// out_ready while a result waits.
// Reset clears only the valid bits of the row and of the output register.
// ----------------------------------------------------------------------------
module load_code_power_resistance_alu import lcpr_pkg::*; #(
  parameter logic [B_W-1:0] MEASURE_MAX_CODE = MEASURE_MAX_CODE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       operation,
  input  logic [A_W-1:0]   first_code,
  input  logic [B_W-1:0]   second_code,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [RES_W-1:0] result_code,
  output logic             saturated,
  output logic             divide_by_zero
);

  logic   advance;
  stage_t chain [N_CELLS+1];

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  lcpr_prep u_prep (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .in_valid    (in_valid),
    .operation   (operation),
    .first_code  (first_code),
    .second_code (second_code),
    .stage_out   (chain[0])
  );

  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    lcpr_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .stage_in  (chain[i]),
      .stage_out (chain[i+1])
    );
  end

  lcpr_finish #(
    .MEASURE_MAX_CODE (MEASURE_MAX_CODE)
  ) u_finish (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .stage_in       (chain[N_CELLS]),
    .out_valid      (out_valid),
    .result_code    (result_code),
    .saturated      (saturated),
    .divide_by_zero (divide_by_zero)
  );

endmodule
